### src/lzjb_block_decompressor_macros.svh
// Assertion macros for the LZJB block decompressor checker.
// Uses i_clk and i_rst_n of the module that expands them.
`ifndef LZJB_BLOCK_DECOMPRESSOR_MACROS_SVH
`define LZJB_BLOCK_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LZJBD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LZJBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/lzjbd_pkg.sv
// Shared types and constants for the LZJB block decompressor.
// No dependencies.
package lzjbd_pkg;

    localparam int WINDOW_BYTES    = 1024;
    localparam int MAX_BLOCK_BYTES = 131072;
    localparam int OUT_LANES       = 2;
    localparam int LEN_BITS        = 6;
    localparam int LEN_BASE        = 3;
    localparam int CFG_W           = 18;
    localparam int QUEUE_DEPTH     = 4;

    localparam int WIN_AW      = $clog2(WINDOW_BYTES);
    localparam int OFF_W       = WIN_AW + 1;
    localparam int PROD_W      = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int CNT_W       = (PROD_W > CFG_W) ? PROD_W : CFG_W;
    localparam int MATCH_LEN_W = $clog2((2 ** LEN_BITS) + LEN_BASE);
    localparam int VCNT_W      = $clog2(OUT_LANES + 1);
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_block;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        first_byte;
        logic [7:0]        second_byte;
        logic [VCNT_W-1:0] valid_count;
        logic              status;
        logic              last_of_run;
        logic              block_done;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_LIT   = 2'd0,
        CMD_MATCH = 2'd1,
        CMD_ERR   = 2'd2
    } t_cmd_kind;

    // One unit of work for the back end: a literal, a copy or an error.
    typedef struct packed {
        t_cmd_kind              kind;
        logic [7:0]             lit_byte;
        logic [MATCH_LEN_W-1:0] len;
        logic [OFF_W-1:0]       off;
        logic [WIN_AW-1:0]      wa;
        logic                   done;
    } t_cmd;

endpackage

### src/lzjbd_front.sv
// Front end: parses the compressed stream into literal/copy/error commands.
// Depends on lzjbd_pkg.
module lzjbd_front import lzjbd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_in_item         i_item,
    input  logic [CFG_W-1:0] i_out_length,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd
);

    typedef enum logic [2:0] {
        PH_FLAG = 3'b001,
        PH_ITEM = 3'b010,
        PH_LOW  = 3'b100
    } t_phase;

    logic [CNT_W-1:0] r_produced, n_produced, c_produced;
    logic [7:0]       r_flag_bits, n_flag_bits, c_flag_bits;
    logic [2:0]       r_flag_pos, n_flag_pos, c_flag_pos;
    logic [7:0]       r_token_high, n_token_high, c_token_high;
    t_phase           r_phase, n_phase, c_phase;
    logic             r_halted, n_halted, c_halted;

    logic [CNT_W-1:0]       cfg_ext, lim, room;
    logic [MATCH_LEN_W-1:0] len_full;
    logic [WIN_AW-1:0]      off_low;
    logic [OFF_W-1:0]       off;
    logic [7:0]             b;
    t_phase                 item_phase;

    assign b        = i_item.in_byte;
    assign cfg_ext  = CNT_W'(i_out_length);
    assign lim      = (cfg_ext > CNT_W'(MAX_BLOCK_BYTES)) ? CNT_W'(MAX_BLOCK_BYTES) : cfg_ext;
    assign len_full = MATCH_LEN_W'(c_token_high[7:8-LEN_BITS]) + MATCH_LEN_W'(LEN_BASE);
    assign off_low  = WIN_AW'({c_token_high, b});
    assign off      = (off_low == '0) ? OFF_W'(WINDOW_BYTES) : OFF_W'(off_low);
    assign room     = lim - c_produced;

    always_comb begin
        // new_block clears block state ahead of the byte
        if (i_item.new_block) begin
            c_produced   = '0;
            c_flag_bits  = '0;
            c_flag_pos   = '0;
            c_token_high = '0;
            c_phase      = PH_FLAG;
            c_halted     = 1'b0;
        end else begin
            c_produced   = r_produced;
            c_flag_bits  = r_flag_bits;
            c_flag_pos   = r_flag_pos;
            c_token_high = r_token_high;
            c_phase      = r_phase;
            c_halted     = r_halted;
        end
    end

    assign item_phase = (&c_flag_pos) ? PH_FLAG : PH_ITEM;

    always_comb begin
        n_produced   = c_produced;
        n_flag_bits  = c_flag_bits;
        n_flag_pos   = c_flag_pos;
        n_token_high = c_token_high;
        n_phase      = c_phase;
        n_halted     = c_halted;
        o_cmd_valid  = 1'b0;
        o_cmd.kind     = CMD_LIT;
        o_cmd.lit_byte = b;
        o_cmd.len      = MATCH_LEN_W'(1);
        o_cmd.off      = off;
        o_cmd.wa       = WIN_AW'(c_produced);
        o_cmd.done     = 1'b0;
        if (!c_halted && (c_produced < lim)) begin
            case (c_phase)
                PH_ITEM: begin
                    if (c_flag_bits[c_flag_pos]) begin
                        n_token_high = b;
                        n_phase      = PH_LOW;
                    end else begin
                        o_cmd_valid = 1'b0 | 1'b1;
                        o_cmd.done  = (room == CNT_W'(1));
                        n_produced  = c_produced + CNT_W'(1);
                        n_halted    = (room == CNT_W'(1));
                        n_flag_pos  = c_flag_pos + 3'd1;
                        n_phase     = item_phase;
                    end
                end
                PH_LOW: begin
                    o_cmd_valid = 1'b1;
                    n_flag_pos  = c_flag_pos + 3'd1;
                    n_phase     = item_phase;
                    if (CNT_W'(off) > c_produced) begin
                        o_cmd.kind = CMD_ERR;
                        n_halted   = 1'b1;
                    end else begin
                        o_cmd.kind = CMD_MATCH;
                        // copy is cut at the block end
                        if (room <= CNT_W'(len_full)) begin
                            o_cmd.len  = MATCH_LEN_W'(room);
                            o_cmd.done = 1'b1;
                            n_produced = lim;
                            n_halted   = 1'b1;
                        end else begin
                            o_cmd.len  = len_full;
                            n_produced = c_produced + CNT_W'(len_full);
                        end
                    end
                end
                default: begin
                    n_flag_bits = b;
                    n_flag_pos  = '0;
                    n_phase     = PH_ITEM;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_produced   <= '0;
            r_flag_bits  <= '0;
            r_flag_pos   <= '0;
            r_token_high <= '0;
            r_phase      <= PH_FLAG;
            r_halted     <= 1'b0;
        end else if (i_accept) begin
            r_produced   <= n_produced;
            r_flag_bits  <= n_flag_bits;
            r_flag_pos   <= n_flag_pos;
            r_token_high <= n_token_high;
            r_phase      <= n_phase;
            r_halted     <= n_halted;
        end
    end

endmodule

### src/lzjbd_fifo.sv
// Command queue between front and back ends.
// Depends on lzjbd_pkg.
module lzjbd_fifo import lzjbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    t_cmd            r_slot [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wp, r_rp;
    logic [QC_W-1:0] r_count;

    assign o_full  = (r_count == QC_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QA_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QA_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QC_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QC_W'(1);
            end
        end
    end

endmodule

### src/lzjbd_back.sv
// Back end: runs commands one byte per cycle when not stalled via the history
// memory and packs bytes into beats of up to two bytes. Depends on lzjbd_pkg.
module lzjbd_back import lzjbd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    typedef struct packed {
        t_cmd_kind         kind;
        logic [7:0]        lit_byte;
        logic [WIN_AW-1:0] wa;
        logic              last;
        logic              done;
    } t_op;

    logic [7:0]        r_hist [WINDOW_BYTES];
    logic [7:0]        r_rd;
    logic              r_busy;
    t_cmd              r_cur;
    logic              r_d_valid;
    t_op               r_d;
    logic              r_hold_valid;
    logic [7:0]        r_hold;
    logic              r_out_valid;
    t_out_item         r_out;

    t_cmd              cur;
    t_cmd              cur_step;
    t_op               op;
    logic              have, issue, adv, needs_out, d_write, d_go;
    logic [WIN_AW-1:0] ra;
    logic [7:0]        d_value;

    assign cur  = r_busy ? r_cur : i_cmd;
    assign have = r_busy || i_cmd_valid;
    assign ra   = cur.wa - WIN_AW'(cur.off);

    // remainder of the command after the byte issued this cycle
    always_comb begin
        cur_step     = cur;
        cur_step.len = cur.len - MATCH_LEN_W'(1);
        cur_step.wa  = cur.wa + WIN_AW'(1);
    end

    assign op.kind     = cur.kind;
    assign op.lit_byte = cur.lit_byte;
    assign op.wa       = cur.wa;
    assign op.last     = (cur.kind != CMD_MATCH) || (cur.len == MATCH_LEN_W'(1));
    assign op.done     = cur.done && op.last;

    // data stage stalls only when it must hand a beat to a full output register
    assign needs_out = (r_d.kind == CMD_ERR) || r_hold_valid || r_d.last;
    assign adv       = !r_d_valid || !needs_out || !r_out_valid || i_out_ready;
    assign issue     = adv && have;
    assign o_cmd_pop = issue && !r_busy;
    assign d_go      = r_d_valid && adv;
    assign d_write   = d_go && (r_d.kind != CMD_ERR);
    assign d_value   = (r_d.kind == CMD_LIT) ? r_d.lit_byte : r_rd;

    // history: write-first so a copy at distance one sees the byte just written
    always_ff @(posedge i_clk) begin
        if (d_write) begin
            r_hist[r_d.wa] <= d_value;
        end
        if (issue) begin
            if (d_write && (r_d.wa == ra)) begin
                r_rd <= d_value;
            end else begin
                r_rd <= r_hist[ra];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_cur <= cur_step;
        end
        if (adv) begin
            r_d <= op;
        end
        if (d_go && (r_d.kind != CMD_ERR) && !r_hold_valid && !r_d.last) begin
            r_hold <= d_value;
        end
        if (d_go && needs_out) begin
            if (r_d.kind == CMD_ERR) begin
                r_out.first_byte  <= '0;
                r_out.second_byte <= '0;
                r_out.valid_count <= '0;
                r_out.status      <= 1'b1;
                r_out.last_of_run <= 1'b1;
                r_out.block_done  <= 1'b0;
            end else if (r_hold_valid) begin
                r_out.first_byte  <= r_hold;
                r_out.second_byte <= d_value;
                r_out.valid_count <= VCNT_W'(2);
                r_out.status      <= 1'b0;
                r_out.last_of_run <= r_d.last;
                r_out.block_done  <= r_d.done;
            end else begin
                r_out.first_byte  <= d_value;
                r_out.second_byte <= '0;
                r_out.valid_count <= VCNT_W'(1);
                r_out.status      <= 1'b0;
                r_out.last_of_run <= 1'b1;
                r_out.block_done  <= r_d.done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_d_valid    <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (issue) begin
                r_busy <= !op.last;
            end
            if (adv) begin
                r_d_valid <= issue;
            end
            if (d_go && (r_d.kind != CMD_ERR)) begin
                r_hold_valid <= !r_hold_valid && !r_d.last;
            end
            if (d_go && needs_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### src/lzjb_block_decompressor.sv
// LZJB block decompressor top level: config register, front end, command
// queue and back end. Depends on lzjbd_pkg, lzjbd_front, lzjbd_fifo, lzjbd_back.
//
//  - Input channel (i_in_valid/o_in_ready/i_in_item): one compressed byte per
//    beat. Set new_block on the first byte of a block to restart it.
//  - Output channel (o_out_valid/i_out_ready/o_out_item): up to two
//    rebuilt bytes per beat, flagged last_of_run on the final beat of each
//    literal or copy and block_done once out_length bytes are out. A bad back
//    offset gives one beat with status set, then the block ignores bytes
//    until the next new_block.
//  - Config channel (i_cfg_valid/o_cfg_ready/i_cfg_data): out_length, always
//    ready; write it only while the block is idle.
//  - Throughput while not stalled: flag, token and literal bytes one per cycle,
//    a copy one output byte per cycle, set by the single byte-wide history port.
//  - An accepted byte's command passes the command queue, the back end's
//    data stage and the output register; a first byte of two waits in r_hold.
//  - Reset clears control state and sets out_length to 131072; the history
//    needs no clearing since copies only read bytes of the current block.
//  - A stalled receiver backs up the back end, then the four-entry command
//    queue, and only then drops o_in_ready.
module lzjb_block_decompressor import lzjbd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_out_length;

    logic in_accept;
    logic cmd_valid;
    t_cmd cmd;
    logic q_full, q_valid, q_pop;
    t_cmd q_head;

    // config register takes a write every cycle it is offered
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_length <= CFG_W'(MAX_BLOCK_BYTES);
        end else if (i_cfg_valid) begin
            r_out_length <= i_cfg_data;
        end
    end

    // one slot free is enough: a byte makes at most one command
    assign o_in_ready = !q_full;
    assign in_accept  = i_in_valid && o_in_ready;

    lzjbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_item       (i_in_item),
        .i_out_length (r_out_length),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    lzjbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept && cmd_valid),
        .i_data  (cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    lzjbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_head),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### src/lzjbd_checker.sv
// Port-level checks on the LZJB block decompressor output channel, bound
// to the top level. Depends on lzjbd_pkg and the assertion macro header.
`include "lzjb_block_decompressor_macros.svh"

module lzjbd_checker import lzjbd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    `LZJBD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid,
        "output beat dropped while stalled")
    `LZJBD_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_item),
        "output beat changed while stalled")
    `LZJBD_ASSERT_IMPLY(a_err_shape, o_out_valid && o_out_item.status,
        (o_out_item.valid_count == '0) && o_out_item.last_of_run && !o_out_item.block_done,
        "error beat malformed")
    `LZJBD_ASSERT_IMPLY(a_empty_is_err, o_out_valid && (o_out_item.valid_count == '0),
        o_out_item.status, "empty beat without error status")

endmodule

bind lzjb_block_decompressor lzjbd_checker u_checker (.*);
